// ===== design/servo_command_frame_encoder_defines.svh =====
// Assertion macros used by the checker of the servo frame encoder.
`ifndef SERVO_COMMAND_FRAME_ENCODER_DEFINES_SVH
`define SERVO_COMMAND_FRAME_ENCODER_DEFINES_SVH

// Checked only while out of reset.
`define SCFE_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SCFE_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== design/scfe_pkg.sv =====
`timescale 1ns / 1ps

package scfe_pkg;

  localparam logic [7:0]  HDR0_BYTE        = 8'hAA;
  localparam logic [7:0]  HDR1_BYTE        = 8'h55;
  localparam logic [7:0]  SET_LENGTH_BYTE  = 8'd7;
  localparam logic [7:0]  READ_DATA_LENGTH = 8'd2;
  localparam logic [7:0]  SET_TAIL_BYTE    = 8'd1;
  localparam logic [7:0]  CRC_POLY         = 8'h8C;
  localparam logic [11:0] ANGLE_MAX        = 12'd2880;
  localparam logic [11:0] PULSE_MIN        = 12'd500;
  localparam logic [4:0]  ANGLE_SCALE      = 5'd25;
  // floor(y / 9) is approximated by (y * 7281) >> 16, at most one short
  localparam logic [12:0] RECIP_NINE       = 13'd7281;
  localparam logic [3:0]  NINE             = 4'd9;
  localparam logic [3:0]  SET_LAST_IDX     = 4'd11;
  localparam logic [3:0]  READ_LAST_IDX    = 4'd6;

  // Request kinds
  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Register indexes
  localparam logic [7:0] REG_DURATION  = 8'd0;
  localparam logic [7:0] REG_FUNCTION  = 8'd1;
  localparam logic [7:0] REG_SET_CODE  = 8'd2;
  localparam logic [7:0] REG_READ_CODE = 8'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_RECIP,
    ST_FIX,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic clamp_en;
    logic recip_en;
    logic fix_en;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_done;
  } dp_status_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/scfe_datapath.sv =====
`timescale 1ns / 1ps

module scfe_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  scfe_pkg::dp_cmd_t   cmd,
  output scfe_pkg::dp_status_t status,
  input  logic                in_func,
  input  logic [7:0]          in_servo_id,
  input  logic signed [12:0]  in_angle,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);

  logic [15:0]        duration_r;
  logic [7:0]         func_code_r;
  logic [7:0]         set_code_r;
  logic [7:0]         read_code_r;

  logic               kind_r;
  logic [7:0]         servo_r;
  logic signed [12:0] angle_r;
  logic [16:0]        scaled_r;
  logic [14:0]        quarter_r;
  logic [27:0]        prod_r;
  logic [11:0]        pulse_r;

  logic [3:0]         idx_r;
  logic [7:0]         crc_r;
  logic               valid_r;
  logic [7:0]         data_r;
  logic               last_r;

  logic [11:0]        angle_clamped;
  logic [14:0]        quarter;
  logic [11:0]        quot;
  logic [15:0]        rem;
  logic [11:0]        quot_fixed;
  logic               slot_free;
  logic               load;
  logic [3:0]         last_idx;
  logic               at_last;
  logic [7:0]         byte_sel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r  <= 16'd500;
      func_code_r <= 8'd4;
      set_code_r  <= 8'd1;
      read_code_r <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        scfe_pkg::REG_DURATION:  duration_r  <= cfg_data;
        scfe_pkg::REG_FUNCTION:  func_code_r <= cfg_data[7:0];
        scfe_pkg::REG_SET_CODE:  set_code_r  <= cfg_data[7:0];
        scfe_pkg::REG_READ_CODE: read_code_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Pulse width: clamp, scale by 25, divide by 36 as (x >> 2) / 9
  always_comb begin
    if (angle_r[12]) begin
      angle_clamped = '0;
    end else if (angle_r[11:0] > scfe_pkg::ANGLE_MAX) begin
      angle_clamped = scfe_pkg::ANGLE_MAX;
    end else begin
      angle_clamped = angle_r[11:0];
    end
  end

  assign quarter    = scaled_r[16:2];
  assign quot       = prod_r[27:16];
  assign rem        = {1'b0, quarter_r} - 16'(quot * scfe_pkg::NINE);
  assign quot_fixed = (rem >= 16'(scfe_pkg::NINE)) ? quot + 12'd1 : quot;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_func;
      servo_r <= in_servo_id;
      angle_r <= in_angle;
    end
    if (cmd.clamp_en) begin
      scaled_r <= 17'(angle_clamped * scfe_pkg::ANGLE_SCALE);
    end
    if (cmd.recip_en) begin
      quarter_r <= quarter;
      prod_r    <= 28'(quarter * scfe_pkg::RECIP_NINE);
    end
    if (cmd.fix_en) begin
      pulse_r <= scfe_pkg::PULSE_MIN + quot_fixed;
    end
  end

  // Byte sequencer
  assign last_idx  = (kind_r == scfe_pkg::KIND_READ) ? scfe_pkg::READ_LAST_IDX
                                                     : scfe_pkg::SET_LAST_IDX;
  assign at_last   = (idx_r == last_idx);
  assign slot_free = !valid_r || out_tready;
  assign load      = cmd.emit && slot_free;

  always_comb begin
    byte_sel = crc_r;
    if (kind_r == scfe_pkg::KIND_READ) begin
      case (idx_r)
        4'd0:    byte_sel = scfe_pkg::HDR0_BYTE;
        4'd1:    byte_sel = scfe_pkg::HDR1_BYTE;
        4'd2:    byte_sel = func_code_r;
        4'd3:    byte_sel = scfe_pkg::READ_DATA_LENGTH;
        4'd4:    byte_sel = read_code_r;
        4'd5:    byte_sel = servo_r;
        default: byte_sel = crc_r;
      endcase
    end else begin
      case (idx_r)
        4'd0:    byte_sel = scfe_pkg::HDR0_BYTE;
        4'd1:    byte_sel = scfe_pkg::HDR1_BYTE;
        4'd2:    byte_sel = func_code_r;
        4'd3:    byte_sel = scfe_pkg::SET_LENGTH_BYTE;
        4'd4:    byte_sel = set_code_r;
        4'd5:    byte_sel = duration_r[7:0];
        4'd6:    byte_sel = duration_r[15:8];
        4'd7:    byte_sel = scfe_pkg::SET_TAIL_BYTE;
        4'd8:    byte_sel = servo_r;
        4'd9:    byte_sel = pulse_r[7:0];
        4'd10:   byte_sel = {4'd0, pulse_r[11:8]};
        default: byte_sel = crc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      crc_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        idx_r <= '0;
        crc_r <= '0;
      end else if (load) begin
        idx_r <= idx_r + 4'd1;
        // header bytes and the crc byte itself stay out of the sum
        if (idx_r >= 4'd2 && !at_last) begin
          crc_r <= scfe_pkg::crc8_step(crc_r, byte_sel);
        end
      end
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= byte_sel;
      last_r <= at_last;
    end
  end

  assign status.frame_done = load && at_last;
  assign out_tvalid        = valid_r;
  assign out_tdata         = data_r;
  assign out_tlast         = last_r;

endmodule

// ===== design/scfe_controller.sv =====
`timescale 1ns / 1ps

module scfe_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_func,
  input  scfe_pkg::dp_status_t status,
  output scfe_pkg::dp_cmd_t    cmd
);

  scfe_pkg::state_t state_r;
  scfe_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scfe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      scfe_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          // read requests carry no angle, so skip the pulse pipeline
          state_nxt = (in_func == scfe_pkg::KIND_READ) ? scfe_pkg::ST_EMIT
                                                       : scfe_pkg::ST_CLAMP;
        end
      end
      scfe_pkg::ST_CLAMP: begin
        cmd.clamp_en = 1'b1;
        state_nxt    = scfe_pkg::ST_RECIP;
      end
      scfe_pkg::ST_RECIP: begin
        cmd.recip_en = 1'b1;
        state_nxt    = scfe_pkg::ST_FIX;
      end
      scfe_pkg::ST_FIX: begin
        cmd.fix_en = 1'b1;
        state_nxt  = scfe_pkg::ST_EMIT;
      end
      scfe_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.frame_done) begin
          state_nxt = scfe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = scfe_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== design/servo_command_frame_encoder.sv =====
`timescale 1ns / 1ps

// Servo command frame encoder. Each request on the in_ channel becomes one
// frame sent a byte per transfer on the out_ channel, with tlast on the
// closing CRC-8/MAXIM byte. A set-position request yields 12 bytes and a
// read-position request 7. A set request passes through the pulse width
// pipeline (clamp and scale, reciprocal multiply, remainder fix-up)
// before its first byte, a read request starts at once, and then the
// sequencer loads one byte per cycle into the output register while the
// sink keeps taking them. A new request is taken once the last byte of
// the frame has been loaded. Registers on the cfg_ port are written in
// any cycle and must only change while no frame is in progress.
module servo_command_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] servo_id, [20:8] angle_sixteenths, [23:21] zero
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] frame_byte
  output logic        out_tlast,  // last_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  scfe_pkg::dp_cmd_t    cmd;
  scfe_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  scfe_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  scfe_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_func     (in_tuser),
    .in_servo_id (in_tdata[7:0]),
    .in_angle    (in_tdata[20:8]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== design/scfe_checker.sv =====
`timescale 1ns / 1ps

`include "servo_command_frame_encoder_defines.svh"

module scfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  `SCFE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")
  `SCFE_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled byte changed")
  `SCFE_ASSERT(a_one_request, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "request taken mid frame")
  `SCFE_ASSERT(a_idle_only_last, clk, rst_n, in_tready && out_tvalid |-> out_tlast, "ready while frame unfinished")

endmodule

bind servo_command_frame_encoder scfe_checker u_scfe_checker (.*);
